// ===== rtl/prc_pkg.sv =====
`default_nettype none

package prc_pkg;

  // configuration of the converter
  localparam int CORDIC_STAGES = 16;
  localparam int COORD_WIDTH   = 16;

  // angle format: 1/128 degree
  localparam int ANGLE_WIDTH  = 16;
  localparam int HALF_TURN    = 23040;
  localparam int QUARTER_TURN = 11520;
  localparam int FULL_TURN    = 46080;

  // internal formats
  localparam int     ZEXTRA          = 12;
  localparam int     RAD_FRAC        = 36;
  localparam longint DEG_PER_RAD_Q16 = 3754936;
  localparam int     MAX_STAGES      = 32;
  localparam int     DW              = 64;
  localparam int     ZW              = 28;
  localparam int     VSHIFT          = 60 - COORD_WIDTH;
  localparam int     SQ_W            = 2 * COORD_WIDTH;
  localparam int     REM_W           = COORD_WIDTH + 2;
  localparam int     MUL_W           = 33;
  localparam int     PROD_W          = COORD_WIDTH + MUL_W;
  localparam int     CO_FRAC         = 30;
  localparam int     VW              = PROD_W - CO_FRAC + 1;

  // one cell per rotation and per root digit, whichever count is larger
  localparam int PIPE_CELLS = (CORDIC_STAGES > COORD_WIDTH) ? CORDIC_STAGES : COORD_WIDTH;
  localparam int IDX_W      = $clog2(PIPE_CELLS);
  localparam int NSTG       = PIPE_CELLS + 4;

  localparam longint COORD_MAX = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
  localparam longint COORD_MIN = -(longint'(1) <<< (COORD_WIDTH - 1));

  // shift and subtract division, elaboration only
  function automatic logic [63:0] const_udiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // floor square root, elaboration only
  function automatic logic [63:0] const_isqrt(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bv;
    n   = n_in;
    res = '0;
    bv  = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (n >= res + bv) begin
        n   = n - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res = res >> 1;
      end
      bv = bv >> 2;
    end
    return res;
  endfunction

  // arctangent of 2^-i in 2^-19 degree
  function automatic logic [63:0] atan_entry(input int i);
    logic [63:0] s;
    logic [63:0] term;
    int          p;
    s = '0;
    if (i == 0) begin
      return 64'd45 << (7 + ZEXTRA);
    end
    for (int k = 0; k < 40; k++) begin
      p = i * (2 * k + 1);
      if (p <= RAD_FRAC) begin
        term = const_udiv(64'd1 << (RAD_FRAC - p), 64'(2 * k + 1));
        if ((k & 1) != 0) begin
          s = s - term;
        end else begin
          s = s + term;
        end
      end
    end
    return (s * 64'(DEG_PER_RAD_Q16) + (64'd1 << 32)) >> 33;
  endfunction

  function automatic logic [MAX_STAGES*ZW-1:0] atan_flat();
    logic [MAX_STAGES*ZW-1:0] f;
    f = '0;
    for (int i = 0; i < MAX_STAGES; i++) begin
      f[i*ZW +: ZW] = ZW'(atan_entry(i));
    end
    return f;
  endfunction

  // reciprocal of the cordic gain in Q30
  function automatic logic [63:0] inv_gain_q30();
    logic [63:0] k2;
    logic [63:0] r;
    k2 = 64'd1 << 31;
    for (int i = 1; i < CORDIC_STAGES && i <= 15; i++) begin
      k2 = (k2 * ((64'd1 << 30) + (64'd1 << (30 - 2 * i)))) >> 30;
    end
    r = const_udiv(64'd1 << 60, k2);
    return const_isqrt(r << 30);
  endfunction

  localparam logic [MAX_STAGES*ZW-1:0] ATAN_FLAT = atan_flat();
  localparam logic [DW-1:0]            INV_GAIN  = inv_gain_q30();

  // data handed from cell to cell
  typedef struct packed {
    logic                          mode;
    logic signed [DW-1:0]          x;
    logic signed [DW-1:0]          y;
    logic signed [ZW-1:0]          z;
    logic [SQ_W-1:0]               sq_n;
    logic [REM_W-1:0]              sq_rem;
    logic [COORD_WIDTH-1:0]        sq_root;
    logic signed [ANGLE_WIDTH-1:0] off;
    logic                          nz;
    logic [COORD_WIDTH-2:0]        radius;
    logic                          neg;
  } cell_t;

endpackage

`default_nettype wire

// ===== rtl/prc_prep.sv =====
`default_nettype none

module prc_prep (
  input  wire logic                                     clk,
  input  wire logic [1:0]                               en,
  input  wire logic                                     op,
  input  wire logic signed [prc_pkg::COORD_WIDTH-1:0]   x_in,
  input  wire logic signed [prc_pkg::COORD_WIDTH-1:0]   y_in,
  input  wire logic [prc_pkg::COORD_WIDTH-2:0]          radius_in,
  input  wire logic signed [prc_pkg::ANGLE_WIDTH-1:0]   angle_in,
  output prc_pkg::cell_t                                cell_o
);

  localparam int CW = prc_pkg::COORD_WIDTH;
  localparam int AW = prc_pkg::ANGLE_WIDTH;

  typedef struct packed {
    logic                        mode;
    logic signed [CW:0]          xa;
    logic signed [CW:0]          ya;
    logic [prc_pkg::SQ_W-1:0]    sq_x;
    logic [prc_pkg::SQ_W-1:0]    sq_y;
    logic signed [AW-1:0]        off;
    logic                        nz;
    logic [CW-2:0]               radius;
    logic signed [AW-1:0]        afold;
    logic                        neg;
  } pre_t;

  pre_t                             pre_r, pre_nxt;
  prc_pkg::cell_t                   cell_r, cell_nxt;
  logic signed [CW:0]               xs, ys;
  logic signed [prc_pkg::SQ_W-1:0]  xw, yw;
  logic signed [AW:0]               a1, a2;

  assign xs = (CW+1)'(x_in);
  assign ys = (CW+1)'(y_in);
  assign xw = prc_pkg::SQ_W'(x_in);
  assign yw = prc_pkg::SQ_W'(y_in);

  // first stage: squares, left half plane mirror, angle wrap and fold
  always_comb begin
    pre_nxt        = '0;
    pre_nxt.mode   = op;
    pre_nxt.sq_x   = xw * xw;
    pre_nxt.sq_y   = yw * yw;
    pre_nxt.nz     = (x_in != '0) || (y_in != '0);
    pre_nxt.radius = radius_in;
    if (x_in[CW-1]) begin
      pre_nxt.xa  = -xs;
      pre_nxt.ya  = -ys;
      pre_nxt.off = y_in[CW-1] ? AW'(-prc_pkg::HALF_TURN) : AW'(prc_pkg::HALF_TURN);
    end else begin
      pre_nxt.xa  = xs;
      pre_nxt.ya  = ys;
      pre_nxt.off = '0;
    end
    a1 = (AW+1)'(angle_in);
    a2 = a1;
    if (a1 > prc_pkg::HALF_TURN) begin
      a2 = a1 - (AW+1)'(prc_pkg::FULL_TURN);
    end else if (a1 < -prc_pkg::HALF_TURN) begin
      a2 = a1 + (AW+1)'(prc_pkg::FULL_TURN);
    end
    pre_nxt.neg = 1'b0;
    if (a2 > prc_pkg::QUARTER_TURN) begin
      a2          = a2 - (AW+1)'(prc_pkg::HALF_TURN);
      pre_nxt.neg = 1'b1;
    end else if (a2 < -prc_pkg::QUARTER_TURN) begin
      a2          = a2 + (AW+1)'(prc_pkg::HALF_TURN);
      pre_nxt.neg = 1'b1;
    end
    pre_nxt.afold = AW'(a2);
  end

  // second stage: start vector, angle and root operand
  always_comb begin
    cell_nxt         = '0;
    cell_nxt.mode    = pre_r.mode;
    cell_nxt.sq_n    = pre_r.sq_x + pre_r.sq_y;
    cell_nxt.off     = pre_r.off;
    cell_nxt.nz      = pre_r.nz;
    cell_nxt.radius  = pre_r.radius;
    cell_nxt.neg     = pre_r.neg;
    if (pre_r.mode) begin
      cell_nxt.x = prc_pkg::INV_GAIN;
      cell_nxt.y = '0;
      cell_nxt.z = prc_pkg::ZW'(pre_r.afold) <<< prc_pkg::ZEXTRA;
    end else begin
      cell_nxt.x = prc_pkg::DW'(pre_r.xa) <<< prc_pkg::VSHIFT;
      cell_nxt.y = prc_pkg::DW'(pre_r.ya) <<< prc_pkg::VSHIFT;
      cell_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pre_r <= pre_nxt;
    end
    if (en[1]) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_o = cell_r;

endmodule

`default_nettype wire

// ===== rtl/prc_cell.sv =====
`default_nettype none

module prc_cell (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [prc_pkg::IDX_W-1:0]   idx,
  input  wire prc_pkg::cell_t              d_i,
  output prc_pkg::cell_t                   d_o
);

  localparam int CW = prc_pkg::COORD_WIDTH;
  localparam int ZW = prc_pkg::ZW;

  prc_pkg::cell_t                 d_r, d_nxt;
  logic signed [prc_pkg::DW-1:0]  sx, sy;
  logic signed [ZW-1:0]           t;
  logic                           ccw;
  logic [prc_pkg::REM_W-1:0]      rem_sh, trial;

  // shifted vector and table angle of this rotation
  assign sx  = d_i.x >>> idx;
  assign sy  = d_i.y >>> idx;
  assign t   = $signed(prc_pkg::ATAN_FLAT[idx*ZW +: ZW]);
  // rotation follows the angle sign, vectoring drives y toward zero
  assign ccw = d_i.mode ? !d_i.z[ZW-1] : d_i.y[prc_pkg::DW-1];

  // one root digit: bring down two operand bits and try the subtraction
  assign rem_sh = {d_i.sq_rem[CW-1:0], d_i.sq_n[prc_pkg::SQ_W-1 -: 2]};
  assign trial  = {d_i.sq_root, 2'b01};

  always_comb begin
    d_nxt = d_i;
    if (int'(idx) < prc_pkg::CORDIC_STAGES) begin
      if (ccw) begin
        d_nxt.x = d_i.x - sy;
        d_nxt.y = d_i.y + sx;
        d_nxt.z = d_i.z - t;
      end else begin
        d_nxt.x = d_i.x + sy;
        d_nxt.y = d_i.y - sx;
        d_nxt.z = d_i.z + t;
      end
    end
    if (int'(idx) < CW) begin
      d_nxt.sq_n = {d_i.sq_n[prc_pkg::SQ_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        d_nxt.sq_rem  = rem_sh - trial;
        d_nxt.sq_root = {d_i.sq_root[CW-2:0], 1'b1};
      end else begin
        d_nxt.sq_rem  = rem_sh;
        d_nxt.sq_root = {d_i.sq_root[CW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;

endmodule

`default_nettype wire

// ===== rtl/prc_post.sv =====
`default_nettype none

module prc_post (
  input  wire logic                                     clk,
  input  wire logic [1:0]                               en,
  input  wire prc_pkg::cell_t                           d_i,
  output logic [prc_pkg::COORD_WIDTH-1:0]               radius_out,
  output logic signed [prc_pkg::ANGLE_WIDTH-1:0]        angle_out,
  output logic signed [prc_pkg::COORD_WIDTH-1:0]        x_out,
  output logic signed [prc_pkg::COORD_WIDTH-1:0]        y_out
);

  localparam int CW = prc_pkg::COORD_WIDTH;
  localparam int AW = prc_pkg::ANGLE_WIDTH;
  localparam int PW = prc_pkg::PROD_W;
  localparam int VW = prc_pkg::VW;

  typedef struct packed {
    logic                 mode;
    logic                 neg;
    logic [CW-1:0]        radius;
    logic signed [AW-1:0] angle;
    logic signed [PW-1:0] px;
    logic signed [PW-1:0] py;
  } mul_t;

  mul_t                        mul_r, mul_nxt;
  logic                        rnd;
  logic signed [prc_pkg::ZW-1:0] zs, zr;
  logic signed [AW+1:0]        asum;
  logic signed [PW-1:0]        rad_s;
  logic [CW-1:0]               radius_r, radius_nxt;
  logic signed [AW-1:0]        angle_r, angle_nxt;
  logic signed [CW-1:0]        x_r, x_nxt, y_r, y_nxt;

  // round half away from zero, mirror, saturate
  function automatic logic signed [CW-1:0] coord_round(input logic signed [PW-1:0] p,
                                                       input logic neg);
    logic [PW-1:0]        mag;
    logic [PW-1:0]        q;
    logic signed [VW-1:0] v;
    mag = p[PW-1] ? PW'(-p) : PW'(p);
    q   = (mag + (PW'(1) << (prc_pkg::CO_FRAC - 1))) >> prc_pkg::CO_FRAC;
    v   = p[PW-1] ? -$signed(VW'(q)) : $signed(VW'(q));
    if (neg) begin
      v = -v;
    end
    if (v > prc_pkg::COORD_MAX) begin
      v = VW'(prc_pkg::COORD_MAX);
    end else if (v < prc_pkg::COORD_MIN) begin
      v = VW'(prc_pkg::COORD_MIN);
    end
    return CW'(v);
  endfunction

  assign rnd   = d_i.sq_rem > prc_pkg::REM_W'(d_i.sq_root);
  assign zs    = d_i.z + prc_pkg::ZW'(1 << (prc_pkg::ZEXTRA - 1));
  assign zr    = zs >>> prc_pkg::ZEXTRA;
  assign asum  = (AW+2)'(d_i.off) + (AW+2)'(zr);
  assign rad_s = PW'($signed({1'b0, d_i.radius}));

  // first stage: rounded radius, angle, radius times cosine and sine
  always_comb begin
    mul_nxt      = '0;
    mul_nxt.mode = d_i.mode;
    mul_nxt.neg  = d_i.neg;
    mul_nxt.px   = rad_s * PW'($signed(d_i.x[prc_pkg::MUL_W-1:0]));
    mul_nxt.py   = rad_s * PW'($signed(d_i.y[prc_pkg::MUL_W-1:0]));
    if (!d_i.mode) begin
      mul_nxt.radius = d_i.sq_root + CW'(rnd);
      if (!d_i.nz) begin
        mul_nxt.angle = '0;
      end else if (asum > prc_pkg::HALF_TURN) begin
        mul_nxt.angle = AW'(prc_pkg::HALF_TURN);
      end else if (asum < -prc_pkg::HALF_TURN) begin
        mul_nxt.angle = AW'(-prc_pkg::HALF_TURN);
      end else begin
        mul_nxt.angle = AW'(asum);
      end
    end
  end

  // second stage: coordinate rounding into the output register
  always_comb begin
    radius_nxt = mul_r.radius;
    angle_nxt  = mul_r.angle;
    if (mul_r.mode) begin
      x_nxt = coord_round(mul_r.px, mul_r.neg);
      y_nxt = coord_round(mul_r.py, mul_r.neg);
    end else begin
      x_nxt = '0;
      y_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mul_r <= mul_nxt;
    end
    if (en[1]) begin
      radius_r <= radius_nxt;
      angle_r  <= angle_nxt;
      x_r      <= x_nxt;
      y_r      <= y_nxt;
    end
  end

  assign radius_out = radius_r;
  assign angle_out  = angle_r;
  assign x_out      = x_r;
  assign y_out      = y_r;

endmodule

`default_nettype wire

// ===== rtl/polar_rect_converter.sv =====
`default_nettype none

// channel   dir   handshake             payload
// in_       in    in_valid / in_stall   in_op, in_x_in, in_y_in, in_radius_in, in_angle_in
// out_      out   out_valid / out_stall out_radius_out, out_angle_out, out_x_out, out_y_out
//
// one item per cycle while in_stall is low; the pipeline is the row of cells, one per
// cordic rotation and square root digit, plus two input and two output stages
// reset clears only the stage valid flags, payload registers are not reset
// a stalled output holds the full stages while empty stages still close up, so
// in_stall rises only when every stage holds an item and the output is stalled

module polar_rect_converter (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     in_valid,
  output logic                                          in_stall,
  input  wire logic                                     in_op,
  input  wire logic signed [prc_pkg::COORD_WIDTH-1:0]   in_x_in,
  input  wire logic signed [prc_pkg::COORD_WIDTH-1:0]   in_y_in,
  input  wire logic [prc_pkg::COORD_WIDTH-2:0]          in_radius_in,
  input  wire logic signed [prc_pkg::ANGLE_WIDTH-1:0]   in_angle_in,
  output logic                                          out_valid,
  input  wire logic                                     out_stall,
  output logic [prc_pkg::COORD_WIDTH-1:0]               out_radius_out,
  output logic signed [prc_pkg::ANGLE_WIDTH-1:0]        out_angle_out,
  output logic signed [prc_pkg::COORD_WIDTH-1:0]        out_x_out,
  output logic signed [prc_pkg::COORD_WIDTH-1:0]        out_y_out
);

  localparam int NSTG  = prc_pkg::NSTG;
  localparam int CELLS = prc_pkg::PIPE_CELLS;

  logic [NSTG-1:0] vld_r, vld_nxt, move;
  prc_pkg::cell_t  chain [CELLS+1];

  // a stage loads when some stage from it to the output is free or the output is not stalled
  for (genvar k = 0; k < NSTG; k++) begin : g_move
    assign move[k] = !(&vld_r[NSTG-1:k]) || !out_stall;
  end

  // valid flags follow the data
  always_comb begin
    vld_nxt[0] = move[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_nxt[k] = move[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !move[0];
  assign out_valid = vld_r[NSTG-1];

  // input stages
  prc_prep u_prep (
    .clk       (clk),
    .en        (move[1:0]),
    .op        (in_op),
    .x_in      (in_x_in),
    .y_in      (in_y_in),
    .radius_in (in_radius_in),
    .angle_in  (in_angle_in),
    .cell_o    (chain[0])
  );

  // row of rotation and root digit cells
  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    prc_cell u_cell (
      .clk (clk),
      .en  (move[k+2]),
      .idx (prc_pkg::IDX_W'(k)),
      .d_i (chain[k]),
      .d_o (chain[k+1])
    );
  end

  // output stages
  prc_post u_post (
    .clk        (clk),
    .en         (move[NSTG-1:NSTG-2]),
    .d_i        (chain[CELLS]),
    .radius_out (out_radius_out),
    .angle_out  (out_angle_out),
    .x_out      (out_x_out),
    .y_out      (out_y_out)
  );

endmodule

`default_nettype wire
